// ===== src/image_convolution_3x3_core_assert.svh =====
// assertion macros for the 3x3 convolution core checker
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef IMAGE_CONVOLUTION_3X3_CORE_ASSERT_SVH
`define IMAGE_CONVOLUTION_3X3_CORE_ASSERT_SVH

// same-cycle implication, idle during reset
`define ICV_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("icv checker: assertion failed");

// next-cycle implication, idle during reset
`define ICV_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("icv checker: assertion failed");

`endif

// ===== src/icv_pkg.sv =====
// shared constants, types and kernel tables for the 3x3 convolution core
// no dependencies
package icv_pkg;

  // frame limits and derived widths
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WEFF_W     = COL_W + 1;
  localparam int HEFF_W     = $clog2(MAX_HEIGHT) + 1;
  localparam int ROW_W      = HEFF_W;

  // register and port widths
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int KS_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SAMPLE_W   = 8;
  localparam int PIX_W      = 3 * SAMPLE_W;
  localparam int LB_W       = 2 * PIX_W;

  // arithmetic widths
  localparam int SUM_W      = 14;
  localparam int MAG_W      = 12;
  localparam int MULT_W     = 13;
  localparam int PROD_W     = MAG_W + MULT_W;
  localparam int SHIFT_W    = 4;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_KERNEL_SELECT,
    CFG_COLOR_MODE
  } icv_cfg_e;

  typedef enum logic [KS_W-1:0] {
    KERN_SMOOTH,
    KERN_BLUR,
    KERN_SHARPEN,
    KERN_MEAN,
    KERN_EMBOSS,
    KERN_IDENTITY
  } icv_kern_e;

  // nine samples of one channel, row-major, top left first
  typedef logic [8:0][SAMPLE_W-1:0] icv_taps_t;

  // per-word control carried down the pipeline
  typedef struct packed {
    logic      started;
    logic      interior;
    logic      last;
    logic      color;
    icv_kern_e kern;
  } icv_ctrl_t;

  // reciprocal of the divisor, exact for all positive sums the kernel can reach
  function automatic logic [MULT_W-1:0] kern_mult(icv_kern_e k);
    logic [MULT_W-1:0] m;
    case (k)
      KERN_SMOOTH:  m = MULT_W'(3641);  // ceil(2^15 / 9)
      KERN_SHARPEN: m = MULT_W'(5462);  // ceil(2^14 / 3)
      default:      m = MULT_W'(1);
    endcase
    return m;
  endfunction

  function automatic logic [SHIFT_W-1:0] kern_shift(icv_kern_e k);
    logic [SHIFT_W-1:0] s;
    case (k)
      KERN_SMOOTH:  s = SHIFT_W'(15);
      KERN_BLUR:    s = SHIFT_W'(4);
      KERN_SHARPEN: s = SHIFT_W'(14);
      default:      s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== src/icv_line_buf.sv =====
// two line stores held side by side in one memory with a read and a write port
// registered read, one write a cycle, write-to-read forwarding; uses icv_pkg
module icv_line_buf import icv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [COL_W-1:0] wr_addr_i,
  input  logic [LB_W-1:0]  wr_data_i,
  output logic [LB_W-1:0]  rd_data_o
);

  logic [LB_W-1:0] mem_q [MAX_WIDTH];
  logic [LB_W-1:0] rd_data_q;
  logic [LB_W-1:0] byp_data_q;
  logic            byp_hit_q;

  // memory array and read register
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q  <= mem_q[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // a read that meets a write to the same column takes the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_hit_q ? byp_data_q : rd_data_q;

endmodule

// ===== src/icv_chan.sv =====
// kernel arithmetic for one colour channel: weighted sum, reciprocal
// multiply, shift and saturate over two register stages; uses icv_pkg
module icv_chan import icv_pkg::*; (
  input  logic                clk_i,
  input  icv_taps_t           taps_i,
  input  icv_kern_e           kern_i,
  output logic [SAMPLE_W-1:0] q_o
);

  logic signed [SUM_W-1:0] tap_s [9];
  logic signed [SUM_W-1:0] corner_sum;
  logic signed [SUM_W-1:0] edge_sum;
  logic signed [SUM_W-1:0] all_sum;
  logic signed [SUM_W-1:0] centre;
  logic signed [SUM_W-1:0] sum_d;
  logic signed [SUM_W-1:0] sum_q;
  icv_kern_e               kern_q;
  logic                    pos_d;
  logic [PROD_W-1:0]       prod_d;
  logic [PROD_W-1:0]       prod_q;
  logic                    pos_q;
  logic [SHIFT_W-1:0]      shift_q;
  logic [PROD_W-1:0]       quo;

  // samples as signed values
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      tap_s[i] = signed'(SUM_W'(taps_i[i]));
    end
  end

  // partial sums shared by the kernels
  assign corner_sum = tap_s[0] + tap_s[2] + tap_s[6] + tap_s[8];
  assign edge_sum   = tap_s[1] + tap_s[3] + tap_s[5] + tap_s[7];
  assign centre     = tap_s[4];
  assign all_sum    = corner_sum + edge_sum + centre;

  // weighted sum of the selected kernel
  always_comb begin
    case (kern_i)
      KERN_SMOOTH:  sum_d = all_sum;
      KERN_BLUR:    sum_d = corner_sum + (edge_sum <<< 1) + (centre <<< 2);
      KERN_SHARPEN: sum_d = (centre <<< 3) + (centre <<< 1) + centre - (edge_sum <<< 1);
      KERN_MEAN:    sum_d = (centre <<< 3) + (centre <<< 1) - all_sum;
      KERN_EMBOSS:  sum_d = tap_s[1] - tap_s[7];
      default:      sum_d = centre;
    endcase
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    kern_q <= kern_i;
  end

  // non-positive sums saturate to zero, so only the magnitude is divided
  assign pos_d  = (sum_q > 0);
  assign prod_d = PROD_W'(sum_q[MAG_W-1:0]) * PROD_W'(kern_mult(kern_q));

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    pos_q   <= pos_d;
    shift_q <= kern_shift(kern_q);
  end

  // quotient and clamp to a byte
  assign quo = prod_q >> shift_q;

  always_comb begin
    if (!pos_q) begin
      q_o = '0;
    end else if (quo > PROD_W'(255)) begin
      q_o = '1;
    end else begin
      q_o = quo[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== src/image_convolution_3x3_core.sv =====
// top level of the 3x3 image convolution core
// uses icv_pkg, icv_line_buf and icv_chan
//
// Pixels enter in raster order, one word per clock, and leave one row plus one
// pixel later in the same order; border pixels pass through, interior pixels take
// the selected kernel (smooth, blur, sharpen, mean, emboss; other codes copy the
// centre; grayscale clears red and green). After a frame send frame_width+1 padding
// words (tuser high) to flush it; the final output word of the frame carries tlast.
// The core sustains one word per clock on both sides unless stalled; a result
// passes the line store read, window, sum and product registers and result queue.
// The line stores are one 2048 x 48 memory with one read and one write per clock
// and need no clearing after reset. An eight-word result queue decouples the
// output, and tready falls only while that queue and the words in flight fill it.
// The user must write configuration only while no frame is in progress.
module image_convolution_3x3_core import icv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // in_red, in_green, in_blue
  input  logic                  s_axis_tuser,   // kind: 0 pixel, 1 padding
  // result output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,   // out_red, out_green, out_blue
  output logic                  m_axis_tlast    // last_of_frame
);

  // configuration registers
  logic [FW_W-1:0]   frame_width_q;
  logic [FH_W-1:0]   frame_height_q;
  logic [KS_W-1:0]   kernel_select_q;
  logic              color_mode_q;

  // position counters
  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [1:0]        in_row_q, in_row_d;   // saturates at two rows
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;

  logic [WEFF_W-1:0] w_eff;
  logic [HEFF_W-1:0] h_eff;
  logic              accept;
  logic              in_wrap, out_wrap;
  logic [COL_W-1:0]  icol0, ocol0;
  logic [1:0]        irow0;
  logic [ROW_W-1:0]  orow0;
  logic [WEFF_W-1:0] icol_inc, ocol_inc;
  logic [ROW_W:0]    orow_inc;
  icv_ctrl_t         ctrl_d;
  icv_kern_e         kern_sel;
  logic [PIX_W-1:0]  pix;

  // pipeline stages
  logic              p1_valid_q, p2_valid_q, p3_valid_q, p4_valid_q;
  icv_ctrl_t         p1_ctrl_q, p2_ctrl_q, p3_ctrl_q, p4_ctrl_q;
  logic [PIX_W-1:0]  p1_pix_q;
  logic [COL_W-1:0]  p1_col_q;
  logic [PIX_W-1:0]  p3_centre_q, p4_centre_q;

  // window and line stores
  logic [PIX_W-1:0]  window_q [9];
  logic [LB_W-1:0]   lb_rd_data;
  logic [PIX_W-1:0]  lb_top, lb_mid;

  // channel datapaths
  icv_taps_t         taps [3];
  logic [SAMPLE_W-1:0] chan_q [3];
  logic [PIX_W-1:0]  res_pix;

  // result queue
  logic [PIX_W:0]        fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] fifo_cnt_q, credit_q, credit_d;
  logic                  push, pop, drop;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= FW_W'(2048);
      frame_height_q  <= FH_W'(4096);
      kernel_select_q <= '0;
      color_mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i[FH_W-1:0];
        CFG_KERNEL_SELECT: kernel_select_q <= cfg_data_i[KS_W-1:0];
        CFG_COLOR_MODE:    color_mode_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // frame size clamped to the supported range
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h_eff = HEFF_W'(1);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      h_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(frame_height_q);
    end
  end

  assign kern_sel = (kernel_select_q > KS_W'(KERN_EMBOSS)) ? KERN_IDENTITY
                                                          : icv_kern_e'(kernel_select_q);

  assign accept = s_axis_tvalid && s_axis_tready;
  assign pix    = s_axis_tuser ? '0 : s_axis_tdata;

  // position bookkeeping for the incoming word
  always_comb begin
    // counters left beyond a narrowed width move to the next row
    in_wrap  = ({1'b0, in_col_q} >= w_eff);
    out_wrap = ({1'b0, out_col_q} >= w_eff);
    icol0    = in_wrap ? '0 : in_col_q;
    irow0    = (in_wrap && in_row_q != 2'd2) ? in_row_q + 2'd1 : in_row_q;
    ocol0    = out_wrap ? '0 : out_col_q;
    orow0    = out_wrap ? out_row_q + ROW_W'(1) : out_row_q;

    icol_inc = {1'b0, icol0} + WEFF_W'(1);
    ocol_inc = {1'b0, ocol0} + WEFF_W'(1);
    orow_inc = {1'b0, orow0} + (ROW_W+1)'(1);

    ctrl_d.started  = (irow0 == 2'd2) || (irow0 == 2'd1 && icol0 != '0);
    ctrl_d.interior = (orow0 != '0) && (ocol0 != '0) && (orow_inc < {1'b0, h_eff})
                      && (ocol_inc < w_eff);
    ctrl_d.last     = (orow_inc >= {1'b0, h_eff}) && (ocol_inc >= w_eff);
    ctrl_d.color    = color_mode_q;
    ctrl_d.kern     = kern_sel;

    if (icol_inc >= w_eff) begin
      in_col_d = '0;
      in_row_d = (irow0 != 2'd2) ? irow0 + 2'd1 : irow0;
    end else begin
      in_col_d = icol_inc[COL_W-1:0];
      in_row_d = irow0;
    end

    out_col_d = ocol0;
    out_row_d = orow0;
    if (ctrl_d.started) begin
      if (ctrl_d.last) begin
        // end of frame: every counter starts over
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (ocol_inc >= w_eff) begin
        out_col_d = '0;
        out_row_d = orow_inc[ROW_W-1:0];
      end else begin
        out_col_d = ocol_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (accept) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
      p4_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= accept;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
      p4_valid_q <= p3_valid_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    p1_ctrl_q   <= ctrl_d;
    p1_pix_q    <= pix;
    p1_col_q    <= icol0;
    p2_ctrl_q   <= p1_ctrl_q;
    p3_ctrl_q   <= p2_ctrl_q;
    p3_centre_q <= window_q[4];
    p4_ctrl_q   <= p3_ctrl_q;
    p4_centre_q <= p3_centre_q;
  end

  // line stores: upper half holds the older row, lower half the newer
  icv_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (icol0),
    .wr_en_i   (p1_valid_q),
    .wr_addr_i (p1_col_q),
    .wr_data_i ({lb_mid, p1_pix_q}),
    .rd_data_o (lb_rd_data)
  );

  assign lb_top = lb_rd_data[LB_W-1:PIX_W];
  assign lb_mid = lb_rd_data[PIX_W-1:0];

  // window shifts left by one column per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        window_q[i] <= '0;
      end
    end else if (p1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        window_q[3*r]   <= window_q[3*r+1];
        window_q[3*r+1] <= window_q[3*r+2];
      end
      window_q[2] <= lb_top;
      window_q[5] <= lb_mid;
      window_q[8] <= p1_pix_q;
    end
  end

  // per-channel kernel arithmetic
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 9; i++) begin
        taps[c][i] = window_q[i][c*SAMPLE_W +: SAMPLE_W];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    icv_chan u_chan (
      .clk_i  (clk_i),
      .taps_i (taps[c]),
      .kern_i (p2_ctrl_q.kern),
      .q_o    (chan_q[c])
    );
  end

  // border pass-through, grayscale clears red and green
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (c != 0 && !p4_ctrl_q.color) begin
        res_pix[c*SAMPLE_W +: SAMPLE_W] = '0;
      end else if (p4_ctrl_q.interior) begin
        res_pix[c*SAMPLE_W +: SAMPLE_W] = chan_q[c];
      end else begin
        res_pix[c*SAMPLE_W +: SAMPLE_W] = p4_centre_q[c*SAMPLE_W +: SAMPLE_W];
      end
    end
  end

  // result queue with credits reserved at accept time
  assign push = p4_valid_q && p4_ctrl_q.started;
  assign drop = p4_valid_q && !p4_ctrl_q.started;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= {p4_ctrl_q.last, res_pix};
    end
  end

  always_comb begin
    credit_d = credit_q;
    if (accept) begin
      credit_d = credit_d + FIFO_CNT_W'(1);
    end
    if (pop) begin
      credit_d = credit_d - FIFO_CNT_W'(1);
    end
    if (drop) begin
      credit_d = credit_d - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      credit_q   <= '0;
    end else begin
      credit_q <= credit_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        fifo_cnt_q <= fifo_cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

  assign s_axis_tready = (credit_q < FIFO_CNT_W'(FIFO_DEPTH));
  assign m_axis_tvalid = (fifo_cnt_q != '0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q][PIX_W-1:0];
  assign m_axis_tlast  = fifo_q[rd_ptr_q][PIX_W];

endmodule

// ===== src/icv_checker.sv =====
// port-level checker for the 3x3 convolution core, bound to the top level
// uses icv_pkg and image_convolution_3x3_core_assert.svh
`include "image_convolution_3x3_core_assert.svh"

module icv_checker import icv_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [PIX_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  logic             in_take;
  logic             out_stall;
  logic [PIX_W:0]   out_word;

  // handshake terms and the full output word
  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tdata};

  // a result offered and not taken stays put
  `ICV_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))

  // an output appearing on an empty queue comes from a word taken at the input earlier
  `ICV_ASSERT_IMPL(a_out_latency, $rose(m_axis_tvalid), $past(in_take, 5))

  // back-pressure starts only when an accepted word uses up the last credit
  `ICV_ASSERT_IMPL(a_ready_fall, $fell(s_axis_tready), $past(in_take))

endmodule

bind image_convolution_3x3_core icv_checker u_icv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
